>>> design/tpag_pkg.sv
package tpag_pkg;

  // Fixed field widths.
  localparam int unsigned IdxW     = 48;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned RankW    = 3;
  localparam int unsigned DimW     = 13;
  localparam int unsigned OrderW   = 8;
  localparam int unsigned FieldW   = 2;
  localparam int unsigned HwAxes   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Parameter defaults.
  localparam int unsigned MaxRankDef = 4;
  localparam int unsigned MaxDimDef  = 4096;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_RANK  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIM0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIM3  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ORDER = 3'd5;

  // Register reset values.
  localparam logic [RankW-1:0]  RankRst  = 3'd1;
  localparam logic [DimW-1:0]   DimRst   = 13'd1;
  localparam logic [OrderW-1:0] OrderRst = 8'd228;

  typedef struct packed {
    logic [ElemW-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  dest_index;
    logic [ElemW-1:0] elem_out;
    logic             is_last;
  } out_item_t;

endpackage

>>> design/tpag_stream_if.sv
interface tpag_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/tensor_permute_address_gen.sv
// Channel   | Direction | Payload                          | Handshake
// ----------+-----------+----------------------------------+-------------
// in_i      | in        | elem_value                       | valid/ready
// out_o     | out       | dest_index, elem_out, is_last    | valid/ready
// cfg       | in        | cfg_idx_i, cfg_data_i            | cfg_we_i
//
// One element request is taken per cycle while in_i.ready is high; its result
// is registered. After reset and after every write to a listed register the
// stride sequencer runs through its two multipliers, with in_i.ready low.
// An output register with a skid register behind it keeps input accepted for
// one more request while the output side stalls.
// Reset (rst_ni, asynchronous, active low) restores the register defaults.
module tensor_permute_address_gen
  import tpag_pkg::*;
#(
  parameter int unsigned MAX_RANK = MaxRankDef,
  parameter int unsigned MAX_DIM  = MaxDimDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tpag_stream_if.sink         in_i,
  tpag_stream_if.source       out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Counter width holds MAX_DIM-1; size width holds MAX_DIM itself.
  localparam int unsigned CntW  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned SizeW = $clog2(MAX_DIM + 1);
  localparam int unsigned AxW   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned PermW = (AxW > FieldW) ? AxW : FieldW;
  localparam int unsigned RW    = $clog2(MAX_RANK + 1);

  // The sequencer first clears, then builds output strides, then the amount
  // each axis takes back when it wraps, then the per-axis index step.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INIT   = 5'b00010,
    ST_STRIDE = 5'b00100,
    ST_BACK   = 5'b01000,
    ST_DELTA  = 5'b10000
  } seq_state_e;

  // Configuration registers.
  logic [RankW-1:0]  rank_q;
  logic [DimW-1:0]   size_q [HwAxes];
  logic [OrderW-1:0] order_q;
  logic              cfg_hit;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CFG_ORDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RankRst;
      order_q <= OrderRst;
      for (int a = 0; a < HwAxes; a++) begin
        size_q[a] <= DimRst;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RANK) begin
        rank_q <= cfg_data_i[RankW-1:0];
      end
      if (cfg_idx_i == CFG_ORDER) begin
        order_q <= cfg_data_i[OrderW-1:0];
      end
      for (int a = 0; a < HwAxes; a++) begin
        if (cfg_idx_i == CfgIdxW'(int'(CFG_DIM0) + a)) begin
          size_q[a] <= cfg_data_i[DimW-1:0];
        end
      end
    end
  end

  // Effective rank: zero counts as one, anything above MAX_RANK saturates.
  logic [RW-1:0] rank_eff;

  always_comb begin
    if (rank_q == '0) begin
      rank_eff = RW'(1);
    end else if (32'(rank_q) > MAX_RANK) begin
      rank_eff = RW'(MAX_RANK);
    end else begin
      rank_eff = RW'(rank_q);
    end
  end

  // Effective sizes: zero counts as one, large sizes saturate to MAX_DIM.
  // Axes without a size register have size one.
  logic [SizeW-1:0] size_eff [MAX_RANK];
  logic [CntW-1:0]  size_m1  [MAX_RANK];

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_size
    if (g < HwAxes) begin : g_reg
      always_comb begin
        if (size_q[g] == '0) begin
          size_eff[g] = SizeW'(1);
        end else if (32'(size_q[g]) > MAX_DIM) begin
          size_eff[g] = SizeW'(MAX_DIM);
        end else begin
          size_eff[g] = SizeW'(size_q[g]);
        end
      end
    end else begin : g_one
      assign size_eff[g] = SizeW'(1);
    end
    assign size_m1[g] = CntW'(size_eff[g] - SizeW'(1));
  end

  // ---------------------------------------------------------------------
  // Stride sequencer
  // ---------------------------------------------------------------------
  seq_state_e      state_q;
  logic [AxW-1:0]  k_q;
  logic            k_last;
  logic            k_used;

  logic [IdxW-1:0] stride_q [MAX_RANK];
  logic [IdxW-1:0] back_q   [MAX_RANK];
  logic [IdxW-1:0] delta_q  [MAX_RANK];
  logic [IdxW-1:0] prod_q;
  logic [IdxW-1:0] suf_q;

  logic [PermW-1:0] perm_k;
  logic             perm_used;
  logic [SizeW-1:0] size_p;
  logic [IdxW-1:0]  stride_k;
  logic [IdxW-1:0]  back_k;
  logic [CntW-1:0]  m1_k;
  logic [IdxW-1:0]  prod_mul;
  logic [IdxW-1:0]  back_mul;

  assign k_last = (k_q == '0);
  assign k_used = (32'(k_q) < 32'(rank_eff));

  // Output position k takes the input axis named in its field; positions
  // beyond the register take their own axis.
  always_comb begin
    perm_k = PermW'(k_q);
    for (int d = 0; d < HwAxes; d++) begin
      if (32'(k_q) == d) begin
        perm_k = PermW'(order_q[FieldW*d +: FieldW]);
      end
    end
  end

  assign perm_used = k_used && (32'(perm_k) < 32'(rank_eff));

  always_comb begin
    size_p   = '0;
    stride_k = '0;
    back_k   = '0;
    m1_k     = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      if (32'(perm_k) == a) begin
        size_p = size_eff[a];
      end
      if (32'(k_q) == a) begin
        stride_k = stride_q[a];
        back_k   = back_q[a];
        m1_k     = size_m1[a];
      end
    end
  end

  assign prod_mul = IdxW'(prod_q * size_p);
  assign back_mul = IdxW'(stride_k * m1_k);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      k_q     <= AxW'(MAX_RANK - 1);
    end else if (cfg_hit) begin
      state_q <= ST_INIT;
      k_q     <= AxW'(MAX_RANK - 1);
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          k_q <= AxW'(MAX_RANK - 1);
        end
        ST_INIT: begin
          state_q <= ST_STRIDE;
          k_q     <= AxW'(MAX_RANK - 1);
        end
        ST_STRIDE, ST_BACK, ST_DELTA: begin
          if (k_last) begin
            k_q <= AxW'(MAX_RANK - 1);
            unique case (state_q)
              ST_STRIDE: state_q <= ST_BACK;
              ST_BACK:   state_q <= ST_DELTA;
              default:   state_q <= ST_IDLE;
            endcase
          end else begin
            k_q <= k_q - AxW'(1);
          end
        end
        default: begin
          state_q <= ST_INIT;
        end
      endcase
    end
  end

  // Sequencer datapath; it works on the data of each state above.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_INIT: begin
        prod_q <= IdxW'(1);
        suf_q  <= '0;
        for (int a = 0; a < MAX_RANK; a++) begin
          stride_q[a] <= '0;
        end
      end
      ST_STRIDE: begin
        if (perm_used) begin
          prod_q <= prod_mul;
          for (int a = 0; a < MAX_RANK; a++) begin
            if (32'(perm_k) == a) begin
              stride_q[a] <= stride_q[a] + prod_q;
            end
          end
        end
      end
      ST_BACK: begin
        for (int a = 0; a < MAX_RANK; a++) begin
          if (32'(k_q) == a) begin
            back_q[a] <= k_used ? back_mul : '0;
          end
        end
      end
      ST_DELTA: begin
        // Stepping axis k adds its stride and takes back what every wrapped
        // inner axis had added.
        suf_q <= suf_q + back_k;
        for (int a = 0; a < MAX_RANK; a++) begin
          if (32'(k_q) == a) begin
            delta_q[a] <= stride_k - suf_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Element path
  // ---------------------------------------------------------------------
  logic [CntW-1:0] cnt_q [MAX_RANK];
  logic [CntW-1:0] cnt_d [MAX_RANK];
  logic [IdxW-1:0] run_q;
  logic [IdxW-1:0] run_d;
  logic [IdxW-1:0] step_sel;
  logic            is_last;
  logic            cnt_zero;
  logic            in_acc;

  always_comb begin
    logic above;
    logic at_max;
    above    = 1'b1;
    step_sel = '0;
    cnt_zero = 1'b1;
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      at_max   = (a >= 32'(rank_eff)) || (cnt_q[a] == size_m1[a]);
      cnt_zero = cnt_zero && (cnt_q[a] == '0);
      cnt_d[a] = cnt_q[a];
      if (above && !at_max) begin
        cnt_d[a] = cnt_q[a] + CntW'(1);
        step_sel = delta_q[a];
      end else if (above) begin
        cnt_d[a] = '0;
      end
      above = above && at_max;
    end
    is_last = above;
    run_d   = is_last ? '0 : run_q + step_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      for (int a = 0; a < MAX_RANK; a++) begin
        cnt_q[a] <= '0;
      end
    end else if (cfg_hit) begin
      run_q <= '0;
      for (int a = 0; a < MAX_RANK; a++) begin
        cnt_q[a] <= '0;
      end
    end else if (in_acc) begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // Output register with a skid register behind it.
  out_item_t out_q;
  out_item_t skid_q;
  out_item_t res;
  logic      out_v_q;
  logic      skid_v_q;
  logic      pop;

  assign res.dest_index = run_q;
  assign res.elem_out   = in_i.data.elem_value;
  assign res.is_last    = is_last;

  assign in_i.ready  = (state_q == ST_IDLE) && !skid_v_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign pop         = out_v_q && out_o.ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_v_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last) |=> (run_q == '0) && cnt_zero)
    else $error("tensor did not restart after its last element");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result ahead of the output register");

  a_cfg_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> !in_i.ready)
    else $error("input accepted while strides are being rebuilt");

  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (run_q == '0) && cnt_zero)
    else $error("register write did not restart the tensor");

endmodule
